// File: hw/rtl/tli_pkg.sv
// shared types and constants for the table linear interpolator
`default_nettype none

package tli_pkg;

   // field widths
   localparam int FIX_W    = 32;
   localparam int IDX_W    = 6;
   localparam int PCNT_W   = 7;
   localparam int STATUS_W = 2;
   localparam int PROD_W   = 2 * FIX_W;
   localparam int STEP_W   = $clog2(PROD_W);
   localparam int SAT_BIT  = 40;

   typedef logic signed [FIX_W-1:0] fixed_type;
   typedef logic [FIX_W-1:0]        mag_type;
   typedef logic [PROD_W-1:0]       prod_type;
   typedef logic [STATUS_W-1:0]     status_type;
   typedef logic [IDX_W-1:0]        index_type;

   // action codes
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // result status codes
   localparam status_type STATUS_INSIDE     = 2'd0;
   localparam status_type STATUS_BEYOND     = 2'd1;
   localparam status_type STATUS_ZERO_WIDTH = 2'd2;
   localparam status_type STATUS_SATURATED  = 2'd3;

   // register indexes
   localparam logic CSR_POINT_COUNT = 1'b0;
   localparam logic CSR_EXTRAPOLATE = 1'b1;

   // register reset values
   localparam logic [PCNT_W-1:0] POINT_COUNT_RESET = 7'd2;
   localparam logic              EXTRAPOLATE_RESET = 1'b1;

   // saturation bounds
   localparam fixed_type FIX_MAX = 32'sh7fff_ffff;
   localparam fixed_type FIX_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

// File: hw/rtl/tli_if.sv
// request and response channel interfaces of the interpolator
`default_nettype none

interface tli_req_if import tli_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      action;
   index_type point_index;
   fixed_type x_value;
   fixed_type y_value;

   modport source (output valid, output action, output point_index,
                   output x_value, output y_value, input ready);
   modport sink   (input valid, input action, input point_index,
                   input x_value, input y_value, output ready);
endinterface

interface tli_rsp_if import tli_pkg::*; ();
   logic       valid;
   logic       ready;
   fixed_type  y_result;
   status_type status;

   modport source (output valid, output y_result, output status, input ready);
   modport sink   (input valid, input y_result, input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tli_table.sv
// breakpoint storage: one write port, one registered read port
`default_nettype none

module tli_table import tli_pkg::*; #(
   parameter int AW = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire fixed_type     wr_x,
   input  wire fixed_type     wr_y,
   input  wire logic [AW-1:0] rd_addr,
   output fixed_type          rd_x,
   output fixed_type          rd_y
);

   fixed_type x_mem [2**AW];
   fixed_type y_mem [2**AW];
   fixed_type rd_x_ff;
   fixed_type rd_y_ff;

   // write on load beats
   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr] <= wr_x;
         y_mem[wr_addr] <= wr_y;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_x_ff <= x_mem[rd_addr];
      rd_y_ff <= y_mem[rd_addr];
   end

   assign rd_x = rd_x_ff;
   assign rd_y = rd_y_ff;

endmodule

`default_nettype wire

// File: hw/rtl/tli_div.sv
// restoring shift-subtract divider, one quotient bit per cycle
`default_nettype none

module tli_div import tli_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire prod_type dividend,
   input  wire mag_type  divisor,
   output logic          done,
   output prod_type      quotient
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   prod_type          dvd_ff, dvd_in;
   mag_type           rem_ff, rem_in;
   mag_type           dsr_ff, dsr_in;

   logic [FIX_W:0] trial;
   logic [FIX_W:0] diff;
   logic           ge;

   // one trial subtraction per cycle, quotient bits shift into the dividend
   always_comb begin
      trial   = {rem_ff, dvd_ff[PROD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      ge      = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[FIX_W-1:0] : trial[FIX_W-1:0];
         dvd_in  = {dvd_ff[PROD_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

// File: hw/rtl/table_linear_interpolator.sv
// Piecewise linear interpolator over a loaded breakpoint table.
// req_bus carries beats of two kinds: a load writes one breakpoint (x, y, Q16.16)
// into slot point_index and gives no response; a query asks for y at x_value and
// gives exactly one rsp_bus beat with y_result and status.
// csr_write_enable with csr_index writes point_count or extrapolate_enable; write
// them only while the block is idle.
// A load is written into the table as it is accepted. A query runs through a
// sequencer: a check of the last interval, an upward scan of one breakpoint per
// cycle over the single table read port, two reads for the interval ends, one
// setup step, one 32x32 multiply and a 64-step shift-subtract divide. The scan
// is skipped when x lies in the last interval; the divider takes most of a
// query's time, and a zero-width interval skips the divide.
// req_bus.ready is high only while the sequencer is idle.
// The result sits in an output register; while the receiver stalls, the
// sequencer waits in its final step and accepts nothing new, but it can take
// the next beat while an earlier result still waits.
// Reset (synchronous, active high) clears the sequencer, the response valid and
// the registers (point_count 2, extrapolation on); table contents are undefined
// until loaded.
`default_nettype none

module table_linear_interpolator import tli_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   tli_req_if.sink                req_bus,
   tli_rsp_if.source              rsp_bus,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_index,
   input  wire logic [PCNT_W-1:0] csr_write_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int PW = ($clog2(MAX_POINTS + 1) > PCNT_W) ? $clog2(MAX_POINTS + 1) : PCNT_W;

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RD_LAST  = 4'd1;
   localparam logic [3:0] S_LAST     = 4'd2;
   localparam logic [3:0] S_RD_SCAN  = 4'd3;
   localparam logic [3:0] S_SCAN     = 4'd4;
   localparam logic [3:0] S_RD_L     = 4'd5;
   localparam logic [3:0] S_GET_L    = 4'd6;
   localparam logic [3:0] S_GET_R    = 4'd7;
   localparam logic [3:0] S_PREP     = 4'd8;
   localparam logic [3:0] S_MUL      = 4'd9;
   localparam logic [3:0] S_DIV_GO   = 4'd10;
   localparam logic [3:0] S_DIV_WAIT = 4'd11;
   localparam logic [3:0] S_FIN      = 4'd12;

   // configuration registers
   logic [PCNT_W-1:0] point_count_ff;
   logic              extrapolate_ff;

   // sequencer and datapath registers
   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] seg_ff, seg_in;
   logic [AW-1:0] last_ff, last_in;
   fixed_type     x_ff, x_in;
   fixed_type     xl_ff, xl_in;
   fixed_type     yl_ff, yl_in;
   fixed_type     xr_ff, xr_in;
   fixed_type     yr_ff, yr_in;
   mag_type       mdy_ff, mdy_in;
   mag_type       mdq_ff, mdq_in;
   mag_type       mdx_ff, mdx_in;
   logic          neg_ff, neg_in;
   logic          beyond_ff, beyond_in;
   logic          zero_ff, zero_in;
   prod_type      prod_ff;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   fixed_type  rsp_y_ff, rsp_y_in;
   status_type rsp_status_ff, rsp_status_in;

   // accept and table signals
   logic          req_accept;
   logic [PW-1:0] idx_ext;
   logic [PW-1:0] pc_ext;
   logic [PW-1:0] n_clamped;
   logic          wr_en;
   fixed_type     rd_x;
   fixed_type     rd_y;

   // divider signals
   logic     div_start;
   logic     div_done;
   prod_type quotient;

   // setup and finish logic
   logic                  x_lt;
   logic                  x_gt;
   fixed_type             yr_hold;
   fixed_type             yl_hold;
   logic signed [FIX_W:0] dy;
   logic signed [FIX_W:0] dx;
   logic signed [FIX_W:0] dq;
   logic [FIX_W+9:0]      sum;
   logic                  out_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= POINT_COUNT_RESET;
         extrapolate_ff <= EXTRAPOLATE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POINT_COUNT: point_count_ff <= csr_write_data;
            CSR_EXTRAPOLATE: extrapolate_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // request handshake and load path
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_accept    = req_bus.valid && (state_ff == S_IDLE);
   assign idx_ext       = PW'(req_bus.point_index);
   assign wr_en         = req_accept && (req_bus.action == ACTION_LOAD) &&
                          (idx_ext < PW'(MAX_POINTS));

   // clamp point count into the table range
   always_comb begin
      pc_ext = PW'(point_count_ff);
      if (pc_ext < PW'(2)) begin
         n_clamped = PW'(2);
      end else if (pc_ext > PW'(MAX_POINTS)) begin
         n_clamped = PW'(MAX_POINTS);
      end else begin
         n_clamped = pc_ext;
      end
   end

   tli_table #(
      .AW (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ext[AW-1:0]),
      .wr_x    (req_bus.x_value),
      .wr_y    (req_bus.y_value),
      .rd_addr (addr_ff),
      .rd_x    (rd_x),
      .rd_y    (rd_y)
   );

   tli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (mdx_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // interval setup: end hold and differences
   always_comb begin
      x_lt    = (x_ff < xl_ff);
      x_gt    = (x_ff > xr_ff);
      yr_hold = (!extrapolate_ff && x_lt) ? yl_ff : yr_ff;
      yl_hold = (!extrapolate_ff && x_gt) ? yr_hold : yl_ff;
      dy      = $signed({yr_hold[FIX_W-1], yr_hold}) - $signed({yl_hold[FIX_W-1], yl_hold});
      dx      = $signed({xr_ff[FIX_W-1], xr_ff}) - $signed({xl_ff[FIX_W-1], xl_ff});
      dq      = $signed({x_ff[FIX_W-1], x_ff}) - $signed({xl_ff[FIX_W-1], xl_ff});
   end

   // final sum with 40-bit quotient limit
   assign sum = yl_ff[FIX_W-1] ? {{10{1'b1}}, yl_ff} : {10'd0, yl_ff};

   always_comb begin
      logic [FIX_W+9:0] total;
      total         = neg_ff ? (sum - {2'b00, quotient[SAT_BIT-1:0]})
                             : (sum + {2'b00, quotient[SAT_BIT-1:0]});
      rsp_y_in      = total[FIX_W-1:0];
      rsp_status_in = beyond_ff ? STATUS_BEYOND : STATUS_INSIDE;
      if (zero_ff) begin
         rsp_y_in      = yl_ff;
         rsp_status_in = STATUS_ZERO_WIDTH;
      end else if (|quotient[PROD_W-1:SAT_BIT]) begin
         rsp_y_in      = neg_ff ? FIX_MIN : FIX_MAX;
         rsp_status_in = STATUS_SATURATED;
      end else if (total[FIX_W+9:FIX_W-1] != {11{1'b0}} &&
                   total[FIX_W+9:FIX_W-1] != {11{1'b1}}) begin
         rsp_y_in      = total[FIX_W+9] ? FIX_MIN : FIX_MAX;
         rsp_status_in = STATUS_SATURATED;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      seg_in       = seg_ff;
      last_in      = last_ff;
      x_in         = x_ff;
      xl_in        = xl_ff;
      yl_in        = yl_ff;
      xr_in        = xr_ff;
      yr_in        = yr_ff;
      mdy_in       = mdy_ff;
      mdq_in       = mdq_ff;
      mdx_in       = mdx_ff;
      neg_in       = neg_ff;
      beyond_in    = beyond_ff;
      zero_in      = zero_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_bus.action == ACTION_QUERY)) begin
               x_in     = req_bus.x_value;
               last_in  = AW'(n_clamped - PW'(2));
               addr_in  = AW'(n_clamped - PW'(2));
               state_in = S_RD_LAST;
            end
         end
         S_RD_LAST: begin
            state_in = S_LAST;
         end
         S_LAST: begin
            if (x_ff >= rd_x) begin
               seg_in   = last_ff;
               addr_in  = last_ff;
               state_in = S_RD_L;
            end else begin
               seg_in   = '0;
               addr_in  = AW'(1);
               state_in = S_RD_SCAN;
            end
         end
         S_RD_SCAN: begin
            addr_in  = addr_ff + 1'b1;
            state_in = S_SCAN;
         end
         // rd_x holds x of breakpoint seg + 1
         S_SCAN: begin
            if ((seg_ff < last_ff) && (x_ff > rd_x)) begin
               seg_in  = seg_ff + 1'b1;
               addr_in = addr_ff + 1'b1;
            end else begin
               addr_in  = seg_ff;
               state_in = S_RD_L;
            end
         end
         S_RD_L: begin
            addr_in  = seg_ff + 1'b1;
            state_in = S_GET_L;
         end
         S_GET_L: begin
            xl_in    = rd_x;
            yl_in    = rd_y;
            state_in = S_GET_R;
         end
         S_GET_R: begin
            xr_in    = rd_x;
            yr_in    = rd_y;
            state_in = S_PREP;
         end
         S_PREP: begin
            yl_in     = yl_hold;
            beyond_in = x_lt || x_gt;
            zero_in   = (xr_ff == xl_ff);
            neg_in    = dy[FIX_W] ^ dx[FIX_W] ^ dq[FIX_W];
            mdy_in    = dy[FIX_W] ? FIX_W'(-dy) : dy[FIX_W-1:0];
            mdx_in    = dx[FIX_W] ? FIX_W'(-dx) : dx[FIX_W-1:0];
            mdq_in    = dq[FIX_W] ? FIX_W'(-dq) : dq[FIX_W-1:0];
            state_in  = S_MUL;
         end
         S_MUL: begin
            state_in = zero_ff ? S_FIN : S_DIV_GO;
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      seg_ff    <= seg_in;
      last_ff   <= last_in;
      x_ff      <= x_in;
      xl_ff     <= xl_in;
      yl_ff     <= yl_in;
      xr_ff     <= xr_in;
      yr_ff     <= yr_in;
      mdy_ff    <= mdy_in;
      mdq_ff    <= mdq_in;
      mdx_ff    <= mdx_in;
      neg_ff    <= neg_in;
      beyond_ff <= beyond_in;
      zero_ff   <= zero_in;
      prod_ff   <= mdy_ff * mdq_ff;
   end

   // response payload loads only when the output register frees up
   always_ff @(posedge clock) begin
      if ((state_ff == S_FIN) && out_free) begin
         rsp_y_ff      <= rsp_y_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.y_result = rsp_y_ff;
   assign rsp_bus.status   = rsp_status_ff;

`ifndef NO_ASSERTIONS
   // a query beat makes the block busy on the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_bus.action == ACTION_QUERY) |=> !req_bus.ready)
      else $error("ready stayed high after a query beat");

   // a new response only comes out of the final step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(state_ff == S_FIN))
      else $error("response valid rose outside the final step");

   // saturated status always carries a bound
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == STATUS_SATURATED) |->
      (rsp_bus.y_result == FIX_MAX || rsp_bus.y_result == FIX_MIN))
      else $error("saturated status with an unclamped value");

   // the divider finishes only while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider done outside the divide wait step");
`endif

endmodule

`default_nettype wire
